// ----- rtl/tssg_pkg.sv -----
package tssg_pkg;

	localparam int COORD_BITS_DEF = 13;
	localparam int COLOUR_BITS    = 4;
	localparam int CMDQ_DEPTH_DEF = 4;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

endpackage

// ----- rtl/tssg_front.sv -----
module tssg_front #(
	parameter int COORD_BITS = tssg_pkg::COORD_BITS_DEF,
	parameter int CMD_W      = 6 * COORD_BITS + tssg_pkg::COLOUR_BITS + 3
) (
	input  logic                                push,
	input  logic                                kind,
	input  logic signed [COORD_BITS-1:0]        ax_in,
	input  logic signed [COORD_BITS-1:0]        ay_in,
	input  logic signed [COORD_BITS-1:0]        bx_in,
	input  logic signed [COORD_BITS-1:0]        by_in,
	input  logic signed [COORD_BITS-1:0]        cx_in,
	input  logic signed [COORD_BITS-1:0]        cy_in,
	input  logic [tssg_pkg::COLOUR_BITS-1:0]    fill_colour,
	input  logic                                q_full,
	output logic                                full,
	output logic                                q_push,
	output logic [CMD_W-1:0]                    q_data
);

	logic signed [COORD_BITS-1:0] xa [3];
	logic signed [COORD_BITS-1:0] ya [3];
	logic signed [COORD_BITS-1:0] xb [3];
	logic signed [COORD_BITS-1:0] yb [3];
	logic signed [COORD_BITS-1:0] xs [3];
	logic signed [COORD_BITS-1:0] ys [3];
	logic sw_a, sw_b, sw_c;
	logic is_load, flat_up, flat_lo;

	// three compare-and-swap stages: (0,1), (0,2), (1,2); swap only on strictly smaller y
	always_comb begin
		sw_a = by_in < ay_in;
		xa[0] = sw_a ? bx_in : ax_in;
		ya[0] = sw_a ? by_in : ay_in;
		xa[1] = sw_a ? ax_in : bx_in;
		ya[1] = sw_a ? ay_in : by_in;
		xa[2] = cx_in;
		ya[2] = cy_in;

		sw_b = ya[2] < ya[0];
		xb[0] = sw_b ? xa[2] : xa[0];
		yb[0] = sw_b ? ya[2] : ya[0];
		xb[1] = xa[1];
		yb[1] = ya[1];
		xb[2] = sw_b ? xa[0] : xa[2];
		yb[2] = sw_b ? ya[0] : ya[2];

		sw_c = yb[2] < yb[1];
		xs[0] = xb[0];
		ys[0] = yb[0];
		xs[1] = sw_c ? xb[2] : xb[1];
		ys[1] = sw_c ? yb[2] : yb[1];
		xs[2] = sw_c ? xb[1] : xb[2];
		ys[2] = sw_c ? yb[1] : yb[2];
	end

	assign is_load = kind == tssg_pkg::KIND_LOAD;
	assign flat_up = is_load && (ys[1] == ys[0]);
	assign flat_lo = is_load && (ys[2] == ys[1]);

	assign full   = q_full;
	assign q_push = push && !q_full;
	assign q_data = {kind, flat_up, flat_lo, fill_colour,
		xs[0], ys[0], xs[1], ys[1], xs[2], ys[2]};

endmodule

// ----- rtl/tssg_cmdq.sv -----
module tssg_cmdq #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tssg_pkg::CMDQ_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: begin
					cnt_q <= cnt_q + 1'b1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule

// ----- rtl/tssg_div.sv -----
module tssg_div #(
	parameter int COORD_BITS = tssg_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [COORD_BITS:0]   num,
	input  logic [COORD_BITS-1:0]        den,
	output logic                         done,
	output logic signed [COORD_BITS:0]   quo,
	output logic [COORD_BITS-1:0]        rem
);

	localparam int W     = COORD_BITS;
	localparam int CNT_W = $clog2(W);

	logic [W:0]       num_abs;
	logic [W-1:0]     sh_q, rem_q, den_q;
	logic             neg_q, run_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W:0]       trial, diff, q_mag;
	logic             ge, rem_nz;

	assign num_abs = num[W] ? $unsigned(-num) : $unsigned(num);

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, sh_q[W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num_abs[W-1:0];
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[W];
		end else if (run_q) begin
			sh_q  <= {sh_q[W-2:0], ge};
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_W'(W - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// floor division for a negative dividend: quotient -(Q+1), remainder den-R when R is nonzero
	assign rem_nz = rem_q != '0;
	assign q_mag  = {1'b0, sh_q} + {{W{1'b0}}, neg_q & rem_nz};
	assign quo    = neg_q ? -$signed(q_mag) : $signed(q_mag);
	assign rem    = (neg_q && rem_nz) ? den_q - rem_q : rem_q;
	assign done   = done_q;

endmodule

// ----- rtl/tssg_back.sv -----
module tssg_back #(
	parameter int COORD_BITS = tssg_pkg::COORD_BITS_DEF,
	parameter int CMD_W      = 6 * COORD_BITS + tssg_pkg::COLOUR_BITS + 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [CMD_W-1:0]                   cmd,
	input  logic                               cmd_empty,
	output logic                               cmd_pop,
	input  logic                               pop,
	output logic                               empty,
	output logic signed [COORD_BITS-1:0]       row,
	output logic signed [COORD_BITS-1:0]       span_start,
	output logic signed [COORD_BITS-1:0]       span_end,
	output logic [tssg_pkg::COLOUR_BITS-1:0]   span_colour,
	output logic                               last
);

	localparam int C = COORD_BITS;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;

	localparam logic [1:0] EDGE_UP = 2'd0;
	localparam logic [1:0] EDGE_LO = 2'd1;
	localparam logic [1:0] EDGE_B  = 2'd2;

	logic                              c_kind, c_flat_up, c_flat_lo;
	logic [tssg_pkg::COLOUR_BITS-1:0]  c_colour;
	logic signed [C-1:0]               c_x0, c_y0, c_x1, c_y1, c_x2, c_y2;

	logic [1:0]                        state_q, e_q;
	logic                              busy_q, lower_q, ovalid_q;
	logic signed [C-1:0]               x_q [3];
	logic signed [C-1:0]               y_q [3];
	logic [tssg_pkg::COLOUR_BITS-1:0]  colour_q;
	logic                              flat_up_q, flat_lo_q;
	logic signed [C:0]                 qstep_q [3];
	logic [C-1:0]                      rstep_q [3];
	logic signed [C-1:0]               aq_q, bq_q, row_q;
	logic [C-1:0]                      arem_q, brem_q;

	logic signed [C:0]                 ex [3];
	logic signed [C:0]                 ey [3];
	logic signed [C:0]                 dy_up_full, dy_lo_full, dy_b_full;
	logic signed [C:0]                 div_num;
	logic [C-1:0]                      div_den;
	logic                              div_start, div_done;
	logic signed [C:0]                 div_quo;
	logic [C-1:0]                      div_rem;

	logic                              head_load, head_step, out_free, emit, at_end;
	logic signed [C-1:0]               end_row, a_x, b_x, lo_x, hi_x;

	logic signed [C:0]                 a_qstep;
	logic [C-1:0]                      a_rstep, a_dy, b_dy;
	logic [C:0]                        a_rsum, a_rdiff, b_rsum, b_rdiff;
	logic                              a_wrap, b_wrap;
	logic [C+1:0]                      a_qsum, b_qsum;

	assign {c_kind, c_flat_up, c_flat_lo, c_colour,
		c_x0, c_y0, c_x1, c_y1, c_x2, c_y2} = cmd;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ex[k] = {x_q[k][C-1], x_q[k]};
			ey[k] = {y_q[k][C-1], y_q[k]};
		end
	end

	assign dy_up_full = ey[1] - ey[0];
	assign dy_lo_full = ey[2] - ey[1];
	assign dy_b_full  = ey[2] - ey[0];

	always_comb begin
		case (e_q)
			EDGE_UP: begin
				div_num = ex[1] - ex[0];
				div_den = dy_up_full[C-1:0];
			end
			EDGE_LO: begin
				div_num = ex[2] - ex[1];
				div_den = dy_lo_full[C-1:0];
			end
			default: begin
				div_num = ex[2] - ex[0];
				div_den = dy_b_full[C-1:0];
			end
		endcase
	end

	assign div_start = state_q == ST_START;

	tssg_div #(
		.COORD_BITS(COORD_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// edge x truncated toward zero from floor quotient and remainder
	assign a_x  = aq_q + {{(C-1){1'b0}}, aq_q[C-1] & (|arem_q)};
	assign b_x  = bq_q + {{(C-1){1'b0}}, bq_q[C-1] & (|brem_q)};
	assign lo_x = (a_x > b_x) ? b_x : a_x;
	assign hi_x = (a_x > b_x) ? a_x : b_x;

	// one-row advance of both edge walkers
	assign a_qstep = lower_q ? qstep_q[EDGE_LO] : qstep_q[EDGE_UP];
	assign a_rstep = lower_q ? rstep_q[EDGE_LO] : rstep_q[EDGE_UP];
	assign a_dy    = lower_q ? dy_lo_full[C-1:0] : dy_up_full[C-1:0];
	assign b_dy    = dy_b_full[C-1:0];

	assign a_rsum  = {1'b0, arem_q} + {1'b0, a_rstep};
	assign a_wrap  = a_rsum >= {1'b0, a_dy};
	assign a_rdiff = a_rsum - {1'b0, a_dy};
	assign a_qsum  = {{2{aq_q[C-1]}}, aq_q} + {a_qstep[C], a_qstep} + {{(C+1){1'b0}}, a_wrap};

	assign b_rsum  = {1'b0, brem_q} + {1'b0, rstep_q[EDGE_B]};
	assign b_wrap  = b_rsum >= {1'b0, b_dy};
	assign b_rdiff = b_rsum - {1'b0, b_dy};
	assign b_qsum  = {{2{bq_q[C-1]}}, bq_q} + {qstep_q[EDGE_B][C], qstep_q[EDGE_B]}
		+ {{(C+1){1'b0}}, b_wrap};

	assign end_row = lower_q ? y_q[2] : y_q[1];
	assign at_end  = row_q >= end_row;

	assign head_load = !cmd_empty && (c_kind == tssg_pkg::KIND_LOAD);
	assign head_step = !cmd_empty && (c_kind == tssg_pkg::KIND_STEP);
	assign out_free  = !ovalid_q || pop;
	// a step with nothing left to draw is dropped without a result
	assign cmd_pop   = (state_q == ST_IDLE) && (head_load || (head_step && (!busy_q || out_free)));
	assign emit      = (state_q == ST_IDLE) && head_step && busy_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			e_q      <= EDGE_UP;
			busy_q   <= 1'b0;
			lower_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop && head_load) begin
						state_q <= ST_START;
						e_q     <= EDGE_UP;
						busy_q  <= 1'b0;
					end else if (emit && at_end) begin
						if (!lower_q && !flat_lo_q) begin
							lower_q <= 1'b1;
						end else begin
							busy_q <= 1'b0;
						end
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_done) begin
						if (e_q == EDGE_B) begin
							state_q <= ST_IDLE;
							busy_q  <= !(flat_up_q && flat_lo_q);
							lower_q <= flat_up_q;
						end else begin
							e_q     <= e_q + 1'b1;
							state_q <= ST_START;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && head_load) begin
			x_q[0]    <= c_x0;
			y_q[0]    <= c_y0;
			x_q[1]    <= c_x1;
			y_q[1]    <= c_y1;
			x_q[2]    <= c_x2;
			y_q[2]    <= c_y2;
			colour_q  <= c_colour;
			flat_up_q <= c_flat_up;
			flat_lo_q <= c_flat_lo;
		end

		if (state_q == ST_WAIT && div_done) begin
			qstep_q[e_q] <= div_quo;
			rstep_q[e_q] <= div_rem;
			if (e_q == EDGE_B) begin
				row_q  <= flat_up_q ? y_q[1] : y_q[0];
				aq_q   <= flat_up_q ? x_q[1] : x_q[0];
				arem_q <= '0;
				bq_q   <= x_q[0];
				brem_q <= '0;
			end
		end

		if (emit) begin
			row         <= row_q;
			span_start  <= lo_x;
			span_end    <= hi_x;
			span_colour <= colour_q;
			last        <= at_end && (lower_q || flat_lo_q);
			if (at_end) begin
				// row y1 is drawn again as the first row of the lower half
				if (!lower_q && !flat_lo_q) begin
					row_q  <= y_q[1];
					aq_q   <= x_q[1];
					arem_q <= '0;
				end
			end else begin
				row_q  <= row_q + 1'b1;
				aq_q   <= a_qsum[C-1:0];
				arem_q <= a_wrap ? a_rdiff[C-1:0] : a_rsum[C-1:0];
				bq_q   <= b_qsum[C-1:0];
				brem_q <= b_wrap ? b_rdiff[C-1:0] : b_rsum[C-1:0];
			end
		end
	end

	assign empty = !ovalid_q;

endmodule

// ----- rtl/triangle_scanline_span_generator.sv -----
// Flat triangle span generator. A load request (kind 0) brings three vertices and a colour; a
// step request (kind 1) yields the next horizontal span, top half then bottom half, with the
// final span flagged by last and no result for a step when no triangle is in progress.
// Requests are sorted on entry and wait in a CMDQ_DEPTH-deep command queue; the walker behind it
// writes the span for a step straight into the result register, so steps sustain one span per
// cycle while results are popped, and the result register refills in the cycle it is popped. A
// load holds the walker for three serial divisions, one quotient bit per cycle, giving the slope
// of each edge per row; edge positions then advance by quotient and remainder, no more division.
module triangle_scanline_span_generator #(
	parameter int COORD_BITS = tssg_pkg::COORD_BITS_DEF,
	parameter int CMDQ_DEPTH = tssg_pkg::CMDQ_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic                               kind,
	input  logic signed [COORD_BITS-1:0]       ax_in,
	input  logic signed [COORD_BITS-1:0]       ay_in,
	input  logic signed [COORD_BITS-1:0]       bx_in,
	input  logic signed [COORD_BITS-1:0]       by_in,
	input  logic signed [COORD_BITS-1:0]       cx_in,
	input  logic signed [COORD_BITS-1:0]       cy_in,
	input  logic [tssg_pkg::COLOUR_BITS-1:0]   fill_colour,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [COORD_BITS-1:0]       row,
	output logic signed [COORD_BITS-1:0]       span_start,
	output logic signed [COORD_BITS-1:0]       span_end,
	output logic [tssg_pkg::COLOUR_BITS-1:0]   span_colour,
	output logic                               last
);

	localparam int CMD_W = 6 * COORD_BITS + tssg_pkg::COLOUR_BITS + 3;

	logic             q_push, q_full, q_empty, q_pop;
	logic [CMD_W-1:0] q_wdata, q_rdata;

	tssg_front #(
		.COORD_BITS (COORD_BITS),
		.CMD_W      (CMD_W)
	) u_front (
		.push        (push),
		.kind        (kind),
		.ax_in       (ax_in),
		.ay_in       (ay_in),
		.bx_in       (bx_in),
		.by_in       (by_in),
		.cx_in       (cx_in),
		.cy_in       (cy_in),
		.fill_colour (fill_colour),
		.q_full      (q_full),
		.full        (full),
		.q_push      (q_push),
		.q_data      (q_wdata)
	);

	tssg_cmdq #(
		.WIDTH (CMD_W),
		.DEPTH (CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	tssg_back #(
		.COORD_BITS (COORD_BITS),
		.CMD_W      (CMD_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (q_rdata),
		.cmd_empty   (q_empty),
		.cmd_pop     (q_pop),
		.pop         (pop),
		.empty       (empty),
		.row         (row),
		.span_start  (span_start),
		.span_end    (span_end),
		.span_colour (span_colour),
		.last        (last)
	);

endmodule

// ----- rtl/tssg_checker.sv -----
module tssg_checker #(
	parameter int COORD_BITS = tssg_pkg::COORD_BITS_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               full,
	input logic                               empty,
	input logic                               pop,
	input logic signed [COORD_BITS-1:0]       row,
	input logic signed [COORD_BITS-1:0]       span_start,
	input logic signed [COORD_BITS-1:0]       span_end,
	input logic [tssg_pkg::COLOUR_BITS-1:0]   span_colour,
	input logic                               last
);

	// a waiting span stays put until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(row) && $stable(span_start)
			&& $stable(span_end) && $stable(span_colour) && $stable(last))
		else $error("span changed while waiting");

	// ends are ordered, empty spans allowed
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && span_start > span_end |-> 1'b0)
		else $error("span start beyond span end");

	// flags read idle once reset has seen a clock
	a_reset: assert property (@(posedge clk)
		!arst_n |=> empty && !full)
		else $error("queue flags not clear in reset");

endmodule

bind triangle_scanline_span_generator tssg_checker #(
	.COORD_BITS (COORD_BITS)
) u_tssg_checker (.*);

// ----- tb/triangle_scanline_span_generator_tb.sv -----
module triangle_scanline_span_generator_tb;

	localparam int CW = tssg_pkg::COORD_BITS_DEF;

	typedef logic signed [CW-1:0]              coord_t;
	typedef logic [tssg_pkg::COLOUR_BITS-1:0]  colour_t;

	typedef struct {
		logic    kind;
		coord_t  ax, ay, bx, by, cx, cy;
		colour_t colour;
	} tri_req_t;

	typedef struct {
		coord_t  row;
		coord_t  x_lo;
		coord_t  x_hi;
		colour_t colour;
		logic    fin;
	} span_t;

	class span_scoreboard;
		bit      walking;
		bit      in_lower;
		longint  next_row;
		longint  vx[3];
		longint  vy[3];
		colour_t tri_col;
		span_t   spans_due[$];
		int      errors;

		function new();
			walking = 0;
			in_lower = 0;
			next_row = 0;
			tri_col = '0;
			errors = 0;
			for (int i = 0; i < 3; i++) begin
				vx[i] = 0;
				vy[i] = 0;
			end
		endfunction

		function void order_pair(int i, int j);
			longint t;
			if (vy[j] < vy[i]) begin
				t = vy[i]; vy[i] = vy[j]; vy[j] = t;
				t = vx[i]; vx[i] = vx[j]; vx[j] = t;
			end
		endfunction

		// exact edge position, truncated toward zero as a whole
		function longint edge_x_at(longint xa, longint ya, longint xb, longint yb, longint r);
			longint dy;
			dy = yb - ya;
			if (dy <= 0)
				return xa;
			return (xa * dy + (r - ya) * (xb - xa)) / dy;
		endfunction

		// returns 1 when the request produces a span
		function bit note_request(tri_req_t rq);
			longint r, xa, xb, end_row, t;
			span_t  sp;
			if (rq.kind == tssg_pkg::KIND_LOAD) begin
				vx[0] = rq.ax; vy[0] = rq.ay;
				vx[1] = rq.bx; vy[1] = rq.by;
				vx[2] = rq.cx; vy[2] = rq.cy;
				tri_col = rq.colour;
				order_pair(0, 1);
				order_pair(0, 2);
				order_pair(1, 2);
				if (vy[1] != vy[0]) begin
					walking = 1; in_lower = 0; next_row = vy[0];
				end else if (vy[2] != vy[1]) begin
					walking = 1; in_lower = 1; next_row = vy[1];
				end else begin
					walking = 0; in_lower = 0; next_row = vy[0];
				end
				return 0;
			end
			if (!walking)
				return 0;
			r = next_row;
			if (!in_lower) begin
				xa = edge_x_at(vx[0], vy[0], vx[1], vy[1], r);
				end_row = vy[1];
			end else begin
				xa = edge_x_at(vx[1], vy[1], vx[2], vy[2], r);
				end_row = vy[2];
			end
			xb = edge_x_at(vx[0], vy[0], vx[2], vy[2], r);
			if (xa > xb) begin
				t = xa; xa = xb; xb = t;
			end
			sp.fin = 1'b0;
			if (r >= end_row) begin
				// middle row is repeated when the lower half follows
				if (!in_lower && vy[2] != vy[1]) begin
					in_lower = 1;
					next_row = vy[1];
				end else begin
					walking = 0;
					sp.fin = 1'b1;
				end
			end else begin
				next_row = r + 1;
			end
			sp.row = coord_t'(r);
			sp.x_lo = coord_t'(xa);
			sp.x_hi = coord_t'(xb);
			sp.colour = tri_col;
			spans_due.insert(spans_due.size(), sp);
			return 1;
		endfunction

		function void check_span(span_t got);
			span_t want;
			if (spans_due.size() == 0) begin
				$error("unexpected span: row %0d start %0d end %0d colour %0d last %0b",
					got.row, got.x_lo, got.x_hi, got.colour, got.fin);
				errors++;
				return;
			end
			want = spans_due.pop_front();
			if (got.row !== want.row) begin
				$error("row: expected %0d, got %0d", want.row, got.row);
				errors++;
			end
			if (got.x_lo !== want.x_lo) begin
				$error("span_start: expected %0d, got %0d", want.x_lo, got.x_lo);
				errors++;
			end
			if (got.x_hi !== want.x_hi) begin
				$error("span_end: expected %0d, got %0d", want.x_hi, got.x_hi);
				errors++;
			end
			if (got.colour !== want.colour) begin
				$error("span_colour: expected %0d, got %0d", want.colour, got.colour);
				errors++;
			end
			if (got.fin !== want.fin) begin
				$error("last: expected %0b, got %0b", want.fin, got.fin);
				errors++;
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    full;
	logic    kind = tssg_pkg::KIND_LOAD;
	coord_t  ax_in = '0;
	coord_t  ay_in = '0;
	coord_t  bx_in = '0;
	coord_t  by_in = '0;
	coord_t  cx_in = '0;
	coord_t  cy_in = '0;
	colour_t fill_colour = '0;
	logic    empty;
	logic    pop = 1'b0;
	coord_t  row;
	coord_t  span_start;
	coord_t  span_end;
	colour_t span_colour;
	logic    last;

	span_scoreboard sb = new();
	int items = 0;
	bit calm = 0;
	bit quiet_in = 0;

	triangle_scanline_span_generator u_top (.*);

	always #4 clk = ~clk;

	function automatic tri_req_t random_req(logic k);
		tri_req_t rq;
		rq.kind = k;
		rq.ax = coord_t'($urandom);
		rq.ay = coord_t'($urandom);
		rq.bx = coord_t'($urandom);
		rq.by = coord_t'($urandom);
		rq.cx = coord_t'($urandom);
		rq.cy = coord_t'($urandom);
		rq.colour = colour_t'($urandom);
		return rq;
	endfunction

	function automatic tri_req_t mk_load(int ax, int ay, int bx, int by, int cx, int cy, int col);
		tri_req_t rq;
		rq.kind = tssg_pkg::KIND_LOAD;
		rq.ax = coord_t'(ax); rq.ay = coord_t'(ay);
		rq.bx = coord_t'(bx); rq.by = coord_t'(by);
		rq.cx = coord_t'(cx); rq.cy = coord_t'(cy);
		rq.colour = colour_t'(col);
		return rq;
	endfunction

	task automatic send(tri_req_t rq);
		if (!calm && !quiet_in && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		push <= 1'b1;
		kind <= rq.kind;
		ax_in <= rq.ax;
		ay_in <= rq.ay;
		bx_in <= rq.bx;
		by_in <= rq.by;
		cx_in <= rq.cx;
		cy_in <= rq.cy;
		fill_colour <= rq.colour;
		do @(posedge clk); while (full);
		if (sb.note_request(rq) || rq.kind == tssg_pkg::KIND_LOAD)
			items++;
	endtask

	task automatic finish_walk(int extra);
		while (sb.walking)
			send(random_req(tssg_pkg::KIND_STEP));
		repeat (extra) send(random_req(tssg_pkg::KIND_STEP));
	endtask

	task automatic random_triangle();
		int h, base, centre, stop_after, cnt;
		int xs[3];
		int ys[3];
		tri_req_t rq;
		h = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
		base = $urandom_range(0, 8191 - h) - 4096;
		centre = $urandom_range(0, 8191 - 80) - 4096 + 40;
		for (int i = 0; i < 3; i++) begin
			ys[i] = base + $urandom_range(0, h);
			if ($urandom_range(0, 1))
				xs[i] = $urandom_range(0, 8191) - 4096;
			else
				xs[i] = centre + $urandom_range(0, 80) - 40;
		end
		// force a flat edge now and then
		if ($urandom_range(0, 5) == 0)
			ys[$urandom_range(0, 2)] = ys[$urandom_range(0, 2)];
		rq = mk_load(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], $urandom_range(0, 15));
		send(rq);
		stop_after = ($urandom_range(0, 7) == 0) ? $urandom_range(0, h) : -1;
		cnt = 0;
		while (sb.walking && cnt != stop_after) begin
			send(random_req(tssg_pkg::KIND_STEP));
			cnt++;
		end
		if (stop_after < 0 && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) send(random_req(tssg_pkg::KIND_STEP));
	endtask

	// result side: random pop stalls, checked on every pop
	initial begin
		int   stall;
		int   cyc;
		bit   quiet_out;
		span_t got;
		stall = 0;
		cyc = 0;
		quiet_out = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				got.row = row;
				got.x_lo = span_start;
				got.x_hi = span_end;
				got.colour = span_colour;
				got.fin = last;
				sb.check_span(got);
			end
			cyc++;
			if (cyc % 100 == 0)
				quiet_out = ($urandom_range(0, 2) == 0);
			if (!arst_n) begin
				pop <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else if (!calm && !quiet_out && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(0, 14);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// step with nothing loaded
		send(random_req(tssg_pkg::KIND_STEP));
		// flat bottom, tie on the lower rows
		send(mk_load(0, 0, 6, 2, -4, 2, 15));
		finish_walk(0);
		// flat top at the x and y extremes
		send(mk_load(-4096, -4096, 4095, -4096, 0, -4094, 10));
		finish_walk(0);
		// both halves, unsorted input, bottom row at the y maximum, then an idle step
		send(mk_load(3, 4093, -2, 4095, 7, 4094, 5));
		finish_walk(1);
		// all three on one row: nothing to draw
		send(mk_load(1, 7, 9, 7, -3, 7, 3));
		send(random_req(tssg_pkg::KIND_STEP));
		// full-height triangle, abandoned by the next load
		send(mk_load(-4096, -4096, 4095, 0, 0, 4095, 0));
		repeat (3) send(random_req(tssg_pkg::KIND_STEP));
		// collinear: edges coincide, empty spans
		send(mk_load(0, 0, 2, 2, 4, 4, 12));
		repeat (2) send(random_req(tssg_pkg::KIND_STEP));

		while (items < 800) begin
			if (items >= 680)
				calm = 1;
			quiet_in = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 9) == 0)
				send(random_req(logic'($urandom_range(0, 1))));
			else
				random_triangle();
		end
		push <= 1'b0;

		while (sb.spans_due.size() != 0)
			@(posedge clk);
		// loads still in the command queue may yet misbehave
		repeat (400) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
